// ----- sv/cosine_similarity_best_row_assert.svh -----
// Assertion macros shared by the checker of the best-row block.
// Depends on nothing; included by the checker file.
`ifndef COSINE_SIMILARITY_BEST_ROW_ASSERT_SVH
`define COSINE_SIMILARITY_BEST_ROW_ASSERT_SVH

// Implication that must hold at every edge outside reset.
`define CSBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define CSBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/csbr_pkg.sv -----
// Types and constants for the cosine similarity best-row block.
// Depends on nothing; imported by the top level, front, queue and back modules.
`timescale 1ns / 1ps
package csbr_pkg;
    localparam int ACC_W   = 40;
    localparam int PROD_W  = 80;
    localparam int ROOT_W  = 42;
    localparam int NUM_W   = 55;
    localparam int SCORE_W = 16;
    localparam int LABEL_W = 3;
    localparam int VAL_W   = 15;
    localparam int OUTIDX_W = 10;

    localparam logic signed [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_NEG_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] NORM_MAX = {ACC_W{1'b1}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7fff;

    // Row summary handed from the front to the back part.
    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        norm_a;
        logic [ACC_W-1:0]        norm_b;
        logic [LABEL_W-1:0]      label;
        logic                    last;
    } row_sum_t;
endpackage

// ----- sv/cosine_similarity_best_row.sv -----
// Top level of the cosine similarity best-row search.
// Depends on csbr_pkg, csbr_front, csbr_queue, csbr_back.
//
//  channel | direction | handshake         | payload
//  in      | in        | in_valid/in_stall | row_value query_value row_label last_in_row last_row
//  out     | out       | out_valid/out_stall | best_row best_label best_score
//
// The front takes one element a cycle (one multiply-accumulate) unless the
// row queue is full. Each row end pushes a summary word into a 4-deep queue.
// The back handles one row at a time: a step to take the word, four 20x20
// partial products of the norm product plus a final add, a 40-step square
// root, a 55-step divide and a compare.
// Rows no shorter than this per-row work therefore run at one element per cycle.
// Reset clears the front's accumulators, the queue and the best-row record.
// out_stall only holds the back; the front runs on until the queue fills.
`timescale 1ns / 1ps
module cosine_similarity_best_row #(
    parameter int MAX_ROWS = 1024,
    parameter int QDEPTH   = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [csbr_pkg::VAL_W-1:0] row_value,
    input  logic signed [csbr_pkg::VAL_W-1:0] query_value,
    input  logic [csbr_pkg::LABEL_W-1:0]      row_label,
    input  logic                              last_in_row,
    input  logic                              last_row,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [csbr_pkg::OUTIDX_W-1:0]     best_row,
    output logic [csbr_pkg::LABEL_W-1:0]      best_label,
    output logic signed [csbr_pkg::SCORE_W-1:0] best_score
);
    import csbr_pkg::*;

    row_sum_t f_sum, q_sum;
    logic f_valid, q_full, q_valid, q_take;

    csbr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .row_value(row_value), .query_value(query_value), .row_label(row_label),
        .last_in_row(last_in_row), .last_row(last_row),
        .sum_valid(f_valid), .sum(f_sum), .sum_full(q_full)
    );

    csbr_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_sum), .full(q_full),
        .rd_valid(q_valid), .rd_data(q_sum), .rd_en(q_take)
    );

    csbr_back #(.MAX_ROWS(MAX_ROWS)) u_back (
        .clk(clk), .rst_n(rst_n), .sum_valid(q_valid), .sum(q_sum), .sum_take(q_take),
        .out_valid(out_valid), .out_stall(out_stall), .best_row(best_row),
        .best_label(best_label), .best_score(best_score)
    );
endmodule

// ----- sv/csbr_ram.sv -----
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
`timescale 1ns / 1ps
module csbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- sv/csbr_front.sv -----
// Front part: MAC of one element per cycle unless stalled; row summary out.
// Depends on csbr_pkg.
`timescale 1ns / 1ps
module csbr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [csbr_pkg::VAL_W-1:0] row_value,
    input  logic signed [csbr_pkg::VAL_W-1:0] query_value,
    input  logic [csbr_pkg::LABEL_W-1:0]      row_label,
    input  logic                              last_in_row,
    input  logic                              last_row,
    output logic                              sum_valid,
    output csbr_pkg::row_sum_t                sum,
    input  logic                              sum_full
);
    import csbr_pkg::*;

    logic signed [ACC_W-1:0] dot_reg, dot_next;
    logic [ACC_W-1:0]        na_reg, na_next, nb_reg, nb_next;
    logic signed [ACC_W+1:0] dsum;
    logic [ACC_W:0]          asum, bsum;
    logic signed [2*VAL_W-1:0] pab, paa, pbb;
    logic                    acc;

    assign in_stall = sum_full;
    assign acc = in_valid && !in_stall;

    always_comb
    begin
        pab  = row_value * query_value;
        paa  = row_value * row_value;
        pbb  = query_value * query_value;
        dsum = (ACC_W+2)'(dot_reg) + (ACC_W+2)'(pab);
        asum = {1'b0, na_reg} + (ACC_W+1)'($unsigned(paa));
        bsum = {1'b0, nb_reg} + (ACC_W+1)'($unsigned(pbb));
        if (dsum > (ACC_W+2)'(ACC_POS_MAX))
        begin
            dot_next = ACC_POS_MAX;
        end
        else if (dsum < (ACC_W+2)'(ACC_NEG_MIN))
        begin
            dot_next = ACC_NEG_MIN;
        end
        else
        begin
            dot_next = dsum[ACC_W-1:0];
        end
        na_next = asum[ACC_W] ? NORM_MAX : asum[ACC_W-1:0];
        nb_next = bsum[ACC_W] ? NORM_MAX : bsum[ACC_W-1:0];
    end

    assign sum_valid   = acc && last_in_row;
    assign sum.dot     = dot_next;
    assign sum.norm_a  = na_next;
    assign sum.norm_b  = nb_next;
    assign sum.label   = row_label;
    assign sum.last    = last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else if (acc)
        begin
            if (last_in_row)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else
            begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end
endmodule

// ----- sv/csbr_queue.sv -----
// Short queue of row summaries between front and back, built on csbr_ram.
// Depends on csbr_pkg and csbr_ram.
`timescale 1ns / 1ps
module csbr_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  csbr_pkg::row_sum_t wr_data,
    output logic               full,
    output logic               rd_valid,
    output csbr_pkg::row_sum_t rd_data,
    input  logic               rd_en
);
    import csbr_pkg::*;
    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] wp_reg, rp_reg, raddr;
    logic [AW:0]   cnt_reg;
    logic          have_reg;
    logic [$bits(row_sum_t)-1:0] rdata;
    logic          pop, load;

    // A word is prefetched into the RAM output register; have_reg marks it.
    // The output register only loads on a pop, so the held word stays put.
    assign load = (cnt_reg != '0) && (!have_reg || rd_en);
    assign pop  = load;
    assign raddr = rp_reg;
    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign rd_valid = have_reg;
    assign rd_data = row_sum_t'(rdata);

    csbr_ram #(.WIDTH($bits(row_sum_t)), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(wr_en), .waddr(wp_reg), .wdata(wr_data),
        .re(load), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(pop);
            if (load)
            begin
                have_reg <= 1'b1;
            end
            else if (rd_en)
            begin
                have_reg <= 1'b0;
            end
        end
    end
endmodule

// ----- sv/csbr_back.sv -----
// Back part: per row, integer square root of the norm product, a bit-serial
// divide, clamp and best-row compare; emits the result after the last row.
// Depends on csbr_pkg.
`timescale 1ns / 1ps
module csbr_back #(
    parameter int MAX_ROWS = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sum_valid,
    input  csbr_pkg::row_sum_t                     sum,
    output logic                                   sum_take,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [csbr_pkg::OUTIDX_W-1:0]          best_row,
    output logic [csbr_pkg::LABEL_W-1:0]           best_label,
    output logic signed [csbr_pkg::SCORE_W-1:0]    best_score
);
    import csbr_pkg::*;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int HALF_W = ACC_W / 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ADD  = 7'b0000100,
        S_SQRT = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    row_sum_t cur_reg;
    logic [1:0] mstep_reg;
    logic [2*HALF_W-1:0] pp_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ROOT_W-1:0] root_reg, rem_reg;
    logic [PROD_W-1:0] pshift_reg;
    logic [6:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [ROOT_W:0] drem_reg;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] bidx_reg;
    logic [LABEL_W-1:0] btag_reg;
    logic signed [SCORE_W-1:0] bval_reg;
    logic have_reg;
    logic zero_norm;

    // Square root: digit-by-digit, two product bits a cycle (restoring).
    logic [ROOT_W+1:0] trial, rem_sh;
    // Divide: one quotient bit a cycle.
    logic [ROOT_W:0] dsh;
    logic [ACC_W-1:0] mag;
    logic signed [SCORE_W-1:0] score;
    logic [HALF_W-1:0] ma, mb;

    assign zero_norm = (cur_reg.norm_a == '0) || (cur_reg.norm_b == '0);
    assign mag = cur_reg.dot[ACC_W-1] ? ACC_W'(-cur_reg.dot) : ACC_W'(cur_reg.dot);

    always_comb
    begin
        ma = mstep_reg[1] ? cur_reg.norm_a[ACC_W-1:HALF_W] : cur_reg.norm_a[HALF_W-1:0];
        mb = mstep_reg[0] ? cur_reg.norm_b[ACC_W-1:HALF_W] : cur_reg.norm_b[HALF_W-1:0];
        rem_sh = {rem_reg, pshift_reg[PROD_W-1:PROD_W-2]};
        trial  = {root_reg, 2'b01};
        dsh    = {drem_reg[ROOT_W-1:0], num_reg[NUM_W-1]};
        if (cur_reg.dot[ACC_W-1])
        begin
            score = (num_reg > NUM_W'(32768)) ? SCORE_MIN : SCORE_W'(-$signed({1'b0, num_reg}));
        end
        else
        begin
            score = (num_reg > NUM_W'(32767)) ? SCORE_MAX : SCORE_W'(num_reg);
        end
        if (zero_norm || root_reg == '0)
        begin
            score = SCORE_MIN;
        end
    end

    assign sum_take  = (state_reg == S_IDLE) && sum_valid;
    assign out_valid = (state_reg == S_OUT);
    assign best_row  = OUTIDX_W'(bidx_reg);
    assign best_label = btag_reg;
    assign best_score = bval_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (sum_valid) state_next = S_MUL;
            S_MUL:  if (mstep_reg == 2'd3) state_next = S_ADD;
            S_ADD:  state_next = S_SQRT;
            S_SQRT: if (cnt_reg == 7'd0) state_next = S_DIV;
            S_DIV:  if (cnt_reg == 7'd0) state_next = S_CMP;
            S_CMP:  state_next = cur_reg.last ? S_OUT : S_IDLE;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cur_reg <= sum;
                mstep_reg <= '0;
                prod_reg <= '0;
                pp_reg <= '0;
            end
            S_MUL:
            begin
                // One 20x20 partial product a cycle, accumulated next cycle.
                pp_reg <= ma * mb;
                mstep_reg <= mstep_reg + 2'd1;
                if (mstep_reg != 2'd0)
                begin
                    prod_reg <= prod_reg + (PROD_W'(pp_reg) << (HALF_W *
                        ((mstep_reg - 2'd1) == 2'd3 ? 2 :
                         ((mstep_reg - 2'd1) == 2'd0 ? 0 : 1))));
                end
            end
            S_ADD:
            begin
                pshift_reg <= prod_reg + (PROD_W'(pp_reg) << (2 * HALF_W));
                root_reg <= '0;
                rem_reg <= '0;
                cnt_reg <= 7'(PROD_W / 2 - 1);
            end
            S_SQRT:
            begin
                pshift_reg <= pshift_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg <= ROOT_W'(rem_sh - trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= ROOT_W'(rem_sh);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == 7'd0)
                begin
                    num_reg <= {mag, 15'd0};
                    drem_reg <= '0;
                    cnt_reg <= 7'(NUM_W - 1);
                end
                else
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
            S_DIV:
            begin
                if (dsh >= {1'b0, root_reg})
                begin
                    drem_reg <= dsh - {1'b0, root_reg};
                    num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dsh;
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg <= '0;
            bidx_reg <= '0;
            btag_reg <= '0;
            bval_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CMP)
            begin
                if (!have_reg || score > bval_reg)
                begin
                    bval_reg <= score;
                    bidx_reg <= row_reg;
                    btag_reg <= cur_reg.label;
                    have_reg <= 1'b1;
                end
                if (row_reg < RW'(MAX_ROWS - 1))
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            if (state_reg == S_OUT && !out_stall)
            begin
                row_reg <= '0;
                bidx_reg <= '0;
                btag_reg <= '0;
                bval_reg <= '0;
                have_reg <= 1'b0;
            end
        end
    end
endmodule

// ----- sv/csbr_checker.sv -----
// Port-level checker for the best-row block, bound to the top level.
// Depends on cosine_similarity_best_row_assert.svh.
`timescale 1ns / 1ps
`include "cosine_similarity_best_row_assert.svh"
module csbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  best_row,
    input logic [15:0] best_score
);
    `CSBR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(best_score))
    `CSBR_ASSERT_NXT(a_row_hold, clk, rst_n, out_valid && out_stall, $stable(best_row))
    `CSBR_ASSERT_NXT(a_out_drop, clk, rst_n, out_valid && !out_stall, !out_valid)
    `CSBR_ASSERT_IMP(a_stall_known, clk, rst_n, 1'b1, !$isunknown(in_stall))
endmodule

bind cosine_similarity_best_row csbr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .best_row(best_row), .best_score(best_score)
);
